@@ rtl/core/bb3_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the 3x3 edge-aware box blur.
// Used by every module of the block; depends on nothing else.
package bb3_pkg;

  localparam int MAX_DIM     = 2048;
  localparam int COL_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = 12;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = CH_W * NUM_CH;
  localparam int ROWS_W      = 2 * PIX_W;
  localparam int CSUM_W      = CH_W + 2;
  localparam int SUM_W       = CH_W + 4;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int RES_W       = FIFO_AW + 1;
  localparam int ENTRY_W     = PIX_W + 1;

  // Configuration register indexes.
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the frame size, stored as size minus one.
  localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(640 - 1);
  localparam logic [COL_W-1:0] HEIGHT_LAST_RST = COL_W'(480 - 1);

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } bb3_div_t;

  // Per-pixel control that travels down the pipeline with each input.
  typedef struct packed {
    logic emit1;   // result centered on the middle window column
    logic emit2;   // result centered on the newest column (row end)
    logic left;    // middle-column result sits on the left frame edge
    logic top;     // output row is the first row of the frame
    logic bottom;  // output row is the last row of the frame
  } bb3_flags_t;

  // Registered window sums, ready for scaling.
  typedef struct packed {
    logic                          emit1;
    logic                          emit2;
    logic                          last;
    bb3_div_t                      div1;
    bb3_div_t                      div2;
    logic [NUM_CH-1:0][SUM_W-1:0]  sum1;
    logic [NUM_CH-1:0][SUM_W-1:0]  sum2;
  } bb3_sums_t;

  // Clamp a programmed size to 2..MAX_DIM and return it minus one.
  function automatic logic [COL_W-1:0] sat_last(input logic [DIM_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v < DIM_W'(2)) begin
      res = COL_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = COL_W'(MAX_DIM - 1);
    end else begin
      res = COL_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  // Reciprocal scaled by 2**RECIP_SHIFT; exact truncation for sums below 8192.
  function automatic logic [RECIP_W-1:0] recip(input bb3_div_t d);
    logic [RECIP_W-1:0] res;
    case (d)
      DIV_BY_4: res = RECIP_W'(8192);
      DIV_BY_6: res = RECIP_W'(5462);
      DIV_BY_9: res = RECIP_W'(3641);
      default:  res = RECIP_W'(8192);
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/bb3_line_store.sv @@
`timescale 1ns / 1ps
// Row store for the blur: one word per column holding the two previous rows.
// Depends on bb3_pkg for widths.
module bb3_line_store import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  output logic [ROWS_W-1:0] rd_data,   // older row in the upper half, previous row below
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [ROWS_W-1:0] wr_data
);

  logic [ROWS_W-1:0] mem [MAX_DIM];
  logic [ROWS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/bb3_window.sv @@
`timescale 1ns / 1ps
// 3x3 pixel window and the clipped neighborhood sums for up to two results.
// Depends on bb3_pkg for types and widths.
module bb3_window import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  bb3_flags_t       in_flags,
  input  logic [PIX_W-1:0] older,
  input  logic [PIX_W-1:0] prev,
  input  logic [PIX_W-1:0] newest,
  output logic             sum_valid,
  output bb3_sums_t        sums
);

  // Window indexed [column][row]; column 2 is the newest, row 0 the oldest.
  logic [2:0][2:0][PIX_W-1:0] win_r;
  logic                       v2_r;
  bb3_flags_t                 flags2_r;
  logic                       v3_r;
  bb3_sums_t                  sums_r;
  bb3_sums_t                  sums_nxt;
  logic [2:0][NUM_CH-1:0][CSUM_W-1:0] csum;
  logic                       rows2;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= {newest, prev, older};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= in_valid;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    flags2_r <= in_flags;
    sums_r   <= sums_nxt;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        csum[k][ch] = (flags2_r.top ? CSUM_W'(0) : CSUM_W'(win_r[k][0][ch*CH_W +: CH_W]))
                    + CSUM_W'(win_r[k][1][ch*CH_W +: CH_W])
                    + (flags2_r.bottom ? CSUM_W'(0)
                                       : CSUM_W'(win_r[k][2][ch*CH_W +: CH_W]));
      end
    end
  end

  always_comb begin
    rows2          = flags2_r.top | flags2_r.bottom;
    sums_nxt.emit1 = v2_r & flags2_r.emit1;
    sums_nxt.emit2 = v2_r & flags2_r.emit2;
    sums_nxt.last  = flags2_r.bottom;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sums_nxt.sum1[ch] = (flags2_r.left ? SUM_W'(0) : SUM_W'(csum[0][ch]))
                        + SUM_W'(csum[1][ch]) + SUM_W'(csum[2][ch]);
      sums_nxt.sum2[ch] = SUM_W'(csum[1][ch]) + SUM_W'(csum[2][ch]);
    end
    if (flags2_r.left && rows2) begin
      sums_nxt.div1 = DIV_BY_4;
    end else if (flags2_r.left || rows2) begin
      sums_nxt.div1 = DIV_BY_6;
    end else begin
      sums_nxt.div1 = DIV_BY_9;
    end
    sums_nxt.div2 = rows2 ? DIV_BY_4 : DIV_BY_6;
  end

  assign sum_valid = v3_r;
  assign sums      = sums_r;

endmodule

@@ rtl/core/bb3_out_queue.sv @@
`timescale 1ns / 1ps
// Scales the window sums to means and queues the results for the output.
// Depends on bb3_pkg for types, the reciprocal table and the queue depth.
module bb3_out_queue import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             sum_valid,
  input  bb3_sums_t        sums,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last
);

  logic [FIFO_DEPTH-1:0][ENTRY_W-1:0] q_r;
  logic [FIFO_AW-1:0]                 wr_ptr_r;
  logic [FIFO_AW-1:0]                 rd_ptr_r;
  logic [RES_W-1:0]                   cnt_r;
  logic [PIX_W-1:0]                   pix1;
  logic [PIX_W-1:0]                   pix2;
  logic [PROD_W-1:0]                  prod1;
  logic [PROD_W-1:0]                  prod2;
  logic                               push1;
  logic                               push2;
  logic                               pop;
  logic [ENTRY_W-1:0]                 first_entry;
  logic [ENTRY_W-1:0]                 second_entry;
  logic [RES_W-1:0]                   npush;

  // Truncated mean as a multiply by the scaled reciprocal.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod1 = PROD_W'(sums.sum1[ch]) * PROD_W'(recip(sums.div1));
      prod2 = PROD_W'(sums.sum2[ch]) * PROD_W'(recip(sums.div2));
      pix1[ch*CH_W +: CH_W] = prod1[RECIP_SHIFT +: CH_W];
      pix2[ch*CH_W +: CH_W] = prod2[RECIP_SHIFT +: CH_W];
    end
  end

  always_comb begin
    push1        = sum_valid & (sums.emit1 | sums.emit2);
    push2        = sum_valid & sums.emit1 & sums.emit2;
    second_entry = {sums.last, pix2};
    first_entry  = sums.emit1 ? {1'b0, pix1} : second_entry;
    npush        = RES_W'(push1) + RES_W'(push2);
    pop          = out_valid & out_ready;
  end

  always_ff @(posedge clk) begin
    if (push1) begin
      q_r[wr_ptr_r] <= first_entry;
    end
    if (push2) begin
      q_r[wr_ptr_r + FIFO_AW'(1)] <= second_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(npush);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + npush - RES_W'(pop);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_pixel = q_r[rd_ptr_r][PIX_W-1:0];
  assign out_last  = q_r[rd_ptr_r][PIX_W];

endmodule

@@ rtl/core/box_blur_3x3_edge_aware.sv @@
`timescale 1ns / 1ps
// Top level of the 3x3 edge-aware box blur; instantiates the row store,
// the window/sum stage and the output queue, all built on bb3_pkg.
//
// Usage:
//   RGB pixels enter in raster order on the in_ stream, one pixel per transfer.
//   Each result is the per-channel truncated mean of the original pixels in
//   the 3x3 neighborhood clipped to the frame (divide by 4 at corners, 6 on
//   edges, 9 inside). Row r is output while row r+1 enters, one pixel behind;
//   the last pixel of an input row also produces the last pixel of the
//   lagging row, so that transfer yields two results. The last frame row is
//   output while row 0 of the next frame enters, and its final pixel carries
//   out_tlast. Row 0 of the very first frame produces no results.
//   A result passes the stage 1, window and sum registers into the queue.
//   Throughput: one input pixel per cycle while the receiver keeps up; the
//   eight-entry output queue absorbs the extra result at each row end.
//   The input side reserves queue room per transfer, so in_tready drops only
//   when the queue and the pipeline together hold too many results; a stalled
//   receiver therefore fills the queue and then holds off the source.
//   Reset empties the pipeline and queue and restores 640x480. A write on the
//   cfg_ port (only while idle) restarts the stream at row 0, column 0 as if
//   no frame had been seen; the row store keeps its contents.
module box_blur_3x3_edge_aware import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Result stream.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // blur_red [7:0], blur_green [15:8], blur_blue [23:16]
  output logic             out_tlast,  // frame_end
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  // Frame size held as size minus one, already clamped.
  logic [COL_W-1:0] w_last_r;
  logic [COL_W-1:0] h_last_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] row_r;
  logic             frame_seen_r;
  logic [RES_W-1:0] res_r;

  logic             in_fire;
  logic             out_fire;
  bb3_flags_t       flags_in;
  logic             active;
  logic [RES_W-1:0] n_new;
  logic [RES_W:0]   res_need;

  // Stage 1: accepted pixel waits here while the row store read completes.
  logic             v1_r;
  logic [PIX_W-1:0] px1_r;
  bb3_flags_t       flags1_r;
  logic [COL_W-1:0] col1_r;
  logic [ROWS_W-1:0] rows_rd;

  logic             sum_valid;
  bb3_sums_t        sums;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  // Output row is the previous input row, or the last row of the previous
  // frame while row 0 of the next frame arrives.
  always_comb begin
    active          = (row_r != '0) | frame_seen_r;
    flags_in.emit1  = active & (col_r != '0);
    flags_in.emit2  = active & (col_r == w_last_r);
    flags_in.left   = (col_r == COL_W'(1));
    flags_in.top    = (row_r == COL_W'(1));
    flags_in.bottom = (row_r == '0);
    n_new           = RES_W'(flags_in.emit1) + RES_W'(flags_in.emit2);
    res_need        = (RES_W + 1)'(res_r) + (RES_W + 1)'(n_new);
    in_tready       = (res_need <= (RES_W + 1)'(FIFO_DEPTH));
  end

  // Frame size and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r     <= WIDTH_LAST_RST;
      h_last_r     <= HEIGHT_LAST_RST;
      col_r        <= '0;
      row_r        <= '0;
      frame_seen_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        w_last_r <= sat_last(cfg_data);
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        h_last_r <= sat_last(cfg_data);
      end
      col_r        <= '0;
      row_r        <= '0;
      frame_seen_r <= 1'b0;
    end else if (in_fire) begin
      if (col_r == w_last_r) begin
        col_r <= '0;
        if (row_r == h_last_r) begin
          row_r        <= '0;
          frame_seen_r <= 1'b1;
        end else begin
          row_r <= row_r + COL_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // Slots held for results that are queued or still in the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_r + (in_fire ? n_new : RES_W'(0)) - RES_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px1_r    <= in_tdata;
      flags1_r <= flags_in;
      col1_r   <= col_r;
    end
  end

  // The previous row moves to the older slot and the new pixel becomes the
  // previous row, both in one word per column.
  bb3_line_store u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rows_rd),
    .wr_en   (v1_r),
    .wr_addr (col1_r),
    .wr_data ({rows_rd[PIX_W-1:0], px1_r})
  );

  bb3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_flags  (flags1_r),
    .older     (rows_rd[ROWS_W-1:PIX_W]),
    .prev      (rows_rd[PIX_W-1:0]),
    .newest    (px1_r),
    .sum_valid (sum_valid),
    .sums      (sums)
  );

  bb3_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sums      (sums),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

  // The reservation count must never promise more than the queue holds.
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_r <= RES_W'(FIFO_DEPTH))
    else $error("result reservation exceeds queue depth");

  // A queued result always has a reservation behind it.
  a_out_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r != '0))
    else $error("output valid without a reserved slot");

  // Position counters stay inside the programmed frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= w_last_r) && (row_r <= h_last_r))
    else $error("position counter outside the frame");

endmodule

@@ bench/box_blur_3x3_edge_aware_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for box_blur_3x3_edge_aware: streams RGB frames through
// the block and checks every blurred pixel against a behavioral predictor.
// Depends on bb3_pkg and the box_blur_3x3_edge_aware RTL only.
module box_blur_3x3_edge_aware_tb;
  import bb3_pkg::*;

  // One expected or observed output pixel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_px_t;

  // Which side of the stream inserts bubbles during the current phase.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SEND,
    STALL_RECV,
    STALL_BOTH
  } stall_mode_t;

  // Cycles to let pass after the last expected result, covering the pipeline
  // registers plus some margin for inputs that produce no result.
  localparam int SETTLE_CYCLES = 8;

  // Input pixels for the whole run, and the most that one random phase sends so
  // that every bubble pattern gets its turn.
  localparam int TOTAL_ITEMS     = 370;
  localparam int PHASE_ITEMS_MAX = 80;

  // Two tiny 2x2 frames: one saturated white, one with mixed channel extremes.
  localparam logic [PIX_W-1:0] TINY_FRAMES [8] = '{
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'h000000, 24'hFF00FF, 24'h00FF00, 24'h7F80FE
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;       // blur_red [7:0], blur_green [15:8], blur_blue [23:16]
  logic             out_tlast;       // frame_end
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  // Pixels waiting to be offered, and blurred pixels waiting to be observed.
  logic [PIX_W-1:0] pixel_backlog [$];
  blur_px_t         pending_blur [$];

  stall_mode_t stall_mode = STALL_NONE;
  int          failures = 0;

  // Predictor state: programmed sizes, the two line buffers, the 3x3 window and
  // the raster position of the next input pixel.
  logic [DIM_W-1:0] width_reg = DIM_W'(640);
  logic [DIM_W-1:0] height_reg = DIM_W'(480);
  bit [PIX_W-1:0]   line_above [MAX_DIM];
  bit [PIX_W-1:0]   line_two_above [MAX_DIM];
  bit [PIX_W-1:0]   window [9];   // index column*3 + row; row 2 is the newest line
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  bit               frame_seen = 1'b0;

  box_blur_3x3_edge_aware DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A programmed size is clamped to 2..MAX_DIM before the block uses it.
  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
    int unsigned res;
    res = v;
    if (res < 2) res = 2;
    if (res > MAX_DIM) res = MAX_DIM;
    return res;
  endfunction

  // Truncated per-channel mean over the window columns and rows that lie inside
  // the frame. The centre column is cc; clipped sides are simply skipped, which
  // gives the divide by 4, 6 or 9.
  function automatic blur_px_t box_mean(input int unsigned cc, input bit left_out,
                                        input bit right_out, input bit top_out,
                                        input bit bottom_out, input bit last);
    int unsigned sum_r, sum_g, sum_b, count, c_lo, c_hi, r_lo, r_hi;
    logic [PIX_W-1:0] px;
    blur_px_t res;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    count = 0;
    c_lo = left_out ? cc : cc - 1;
    c_hi = right_out ? cc : cc + 1;
    r_lo = top_out ? 1 : 0;
    r_hi = bottom_out ? 1 : 2;
    for (int unsigned c = c_lo; c <= c_hi; c++) begin
      for (int unsigned r = r_lo; r <= r_hi; r++) begin
        px = window[(c * 3 + r) % 9];
        sum_r += px[7:0];
        sum_g += px[15:8];
        sum_b += px[23:16];
        count++;
      end
    end
    if (count == 0) count = 1;
    res.red = CH_W'(sum_r / count);
    res.green = CH_W'(sum_g / count);
    res.blue = CH_W'(sum_b / count);
    res.frame_end = last;
    return res;
  endfunction

  // Advance the predictor by one accepted pixel and queue the blurred pixels it
  // releases. Output row r trails input row r+1 by one pixel; the last pixel of
  // an input row also releases the last pixel of the trailing row. The bottom
  // row of a frame is released while row 0 of the next frame streams in.
  task automatic follow_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r, orow;
    logic [PIX_W-1:0] older, prev;
    bit active, top_out, bottom_out;
    w = clip_dim(width_reg);
    h = clip_dim(height_reg);
    c = col_pos;
    r = row_pos;
    orow = 0;
    active = 1'b0;
    top_out = 1'b0;
    bottom_out = 1'b0;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    older = line_two_above[c];
    prev = line_above[c];
    line_two_above[c] = prev;
    line_above[c] = px;
    for (int i = 0; i < 6; i++) window[i] = window[i + 3];
    window[6] = older;
    window[7] = prev;
    window[8] = px;
    if (r >= 1) begin
      active = 1'b1;
      orow = r - 1;
      top_out = (orow == 0);
    end else if (frame_seen) begin
      active = 1'b1;
      orow = h - 1;
      bottom_out = 1'b1;
    end
    if (active && c >= 1)
      pending_blur.push_back(box_mean(1, c == 1, 1'b0, top_out, bottom_out, 1'b0));
    if (active && c == w - 1)
      pending_blur.push_back(box_mean(2, 1'b0, 1'b1, top_out, bottom_out, orow == h - 1));
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        frame_seen = 1'b1;
      end
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic bit send_idle();
    bit res;
    res = 1'b0;
    if (stall_mode == STALL_SEND) res = ($urandom_range(99) < 65);
    if (stall_mode == STALL_BOTH) res = ($urandom_range(99) < 13);
    return res;
  endfunction

  function automatic bit recv_stall();
    bit res;
    res = 1'b0;
    if (stall_mode == STALL_RECV) res = ($urandom_range(99) < 65);
    if (stall_mode == STALL_BOTH) res = ($urandom_range(99) < 13);
    return res;
  endfunction

  // Mostly uniform channel values, with the two extremes mixed in often.
  function automatic logic [CH_W-1:0] rand_channel();
    logic [CH_W-1:0] res;
    case ($urandom_range(9))
      0:       res = 8'h00;
      1:       res = 8'hFF;
      default: res = CH_W'($urandom_range(255));
    endcase
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  // Driver: keeps tvalid and tdata stable until the transfer completes, then
  // either offers the next backlog pixel or inserts a bubble.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pixel_backlog.size() != 0 && !send_idle()) begin
        in_tvalid <= 1'b1;
        in_tdata <= pixel_backlog.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: feeds every accepted input pixel to the predictor, and checks
  // every output transfer against the oldest expected blurred pixel.
  always @(posedge clk) begin
    blur_px_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_stall();
      if (in_tvalid && in_tready) follow_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_blur.size() == 0) begin
          $error("unexpected output transfer: tdata %h tlast %b", out_tdata, out_tlast);
          failures++;
        end else begin
          want = pending_blur.pop_front();
          if (out_tdata[7:0] !== want.red) begin
            $error("blur_red: expected %0d, got %0d", want.red, out_tdata[7:0]);
            failures++;
          end
          if (out_tdata[15:8] !== want.green) begin
            $error("blur_green: expected %0d, got %0d", want.green, out_tdata[15:8]);
            failures++;
          end
          if (out_tdata[23:16] !== want.blue) begin
            $error("blur_blue: expected %0d, got %0d", want.blue, out_tdata[23:16]);
            failures++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_tlast);
            failures++;
          end
        end
      end
    end
  end

  // Wait (on falling edges, where queues and handshakes are settled) until the
  // backlog is drained, no pixel is on the bus and every expected result came.
  task automatic drain();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_tvalid || pending_blur.size() != 0);
  endtask

  // Drain, then give pixels that release no result time to leave the pipeline
  // so that a register write never lands on a busy block.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; the predictor restarts the raster exactly as the block
  // does, keeping the line buffers and window.
  task automatic write_reg(input logic [0:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
    frame_seen = 1'b0;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pixel_backlog.push_back(rand_pixel());
  endtask

  initial begin
    int sent;
    int phase;
    int w, h, n;
    sent = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Programmed sizes below the minimum clamp to a 2x2 frame. Two frames back
    // to back: the second one's top row releases the first one's bottom row,
    // so every result here is a corner.
    set_frame(DIM_W'(0), DIM_W'(1));
    foreach (TINY_FRAMES[i]) pixel_backlog.push_back(TINY_FRAMES[i]);
    sent += 8;

    // A 3x3 ramp, one row into the next frame, reaches the centre pixel and the
    // top, bottom, left and right edges.
    set_frame(DIM_W'(3), DIM_W'(3));
    for (int k = 0; k < 12; k++)
      pixel_backlog.push_back({(k % 2) ? 8'hFF : 8'h00, CH_W'(255 - k * 23), CH_W'(k * 23)});
    sent += 12;

    // Writing the same width again must still restart the raster at row 0.
    settle();
    write_reg(REG_FRAME_WIDTH, DIM_W'(3));
    push_random(6);
    sent += 6;

    // Random phases of small frames, each fed one to three whole frames and up to one
    // more, capped at PHASE_ITEMS_MAX pixels, under a rotating bubble pattern.
    while (sent < TOTAL_ITEMS) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      if ($urandom_range(9) == 0) w = $urandom_range(1);
      if ($urandom_range(9) == 0) h = $urandom_range(1);
      set_frame(DIM_W'(w), DIM_W'(h));
      stall_mode = stall_mode_t'(phase % 4);
      n = $urandom_range(1, 3) * clip_dim(w) * clip_dim(h) +
          $urandom_range(clip_dim(w) * clip_dim(h));
      if (n > PHASE_ITEMS_MAX) n = PHASE_ITEMS_MAX;
      if (n > TOTAL_ITEMS - sent) n = TOTAL_ITEMS - sent;
      if (phase == 1) begin
        // Hold the source back in mid-frame until the block has caught up.
        push_random(n / 2);
        drain();
        push_random(n - n / 2);
      end else begin
        push_random(n);
      end
      sent += n;
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("box_blur_3x3_edge_aware test passed");
    end else begin
      $display("box_blur_3x3_edge_aware test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("box_blur_3x3_edge_aware test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bb3_pkg.sv
rtl/core/bb3_line_store.sv
rtl/core/bb3_window.sv
rtl/core/bb3_out_queue.sv
rtl/core/box_blur_3x3_edge_aware.sv
bench/box_blur_3x3_edge_aware_tb.sv
